// ===== rtl/rwlm_pkg.sv =====
// ----------------------------------------------------------------------------
// rwlm_pkg: shared types and codes for the readers-writers lock manager
// Request and result payloads, opcodes, result kinds and the internal
// command passed from the front end to the back end.
// ----------------------------------------------------------------------------
package rwlm_pkg;

	// Request opcodes
	localparam logic [2:0] OP_READ    = 3'd0;
	localparam logic [2:0] OP_WRITE   = 3'd1;
	localparam logic [2:0] OP_RELEASE = 3'd2;
	localparam logic [2:0] OP_LOCK    = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;

	// Result kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_DROP  = 2'd2;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] resource;
		logic [7:0] requester;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] grantee;
		logic [3:0] res_index;
		logic       is_locked;
		logic       last;
	} rsp_t;

	typedef enum logic [2:0] {
		CMD_READ,
		CMD_WRITE,
		CMD_RELEASE,
		CMD_LOCK,
		CMD_CLEAR,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [3:0] resource;
		logic [7:0] requester;
	} cmd_t;

endpackage

// ===== rtl/rwlm_ram.sv =====
// ----------------------------------------------------------------------------
// rwlm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rwlm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/rwlm_front.sv =====
// ----------------------------------------------------------------------------
// rwlm_front: request intake and classification
// Decodes each request into a command, filters bad resources and unused
// opcodes, and holds commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rwlm_front #(
	parameter int NUM_RESOURCES = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  rwlm_pkg::req_t req,
	output logic           cmd_valid,
	output rwlm_pkg::cmd_t cmd,
	input  logic           cmd_pop
);

	rwlm_pkg::cmd_t cmd_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	rwlm_pkg::cmd_t cls;
	logic           in_range;
	logic           do_push;
	logic           do_pop;

	// Classify the incoming request
	always_comb begin
		in_range     = 32'(req.resource) < NUM_RESOURCES;
		cls.resource = req.resource;
		cls.requester = req.requester;
		case (req.op)
			rwlm_pkg::OP_READ:    cls.kind = in_range ? rwlm_pkg::CMD_READ    : rwlm_pkg::CMD_NOP;
			rwlm_pkg::OP_WRITE:   cls.kind = in_range ? rwlm_pkg::CMD_WRITE   : rwlm_pkg::CMD_NOP;
			rwlm_pkg::OP_RELEASE: cls.kind = in_range ? rwlm_pkg::CMD_RELEASE : rwlm_pkg::CMD_NOP;
			rwlm_pkg::OP_LOCK:    cls.kind = in_range ? rwlm_pkg::CMD_LOCK    : rwlm_pkg::CMD_NOP;
			rwlm_pkg::OP_CLEAR:   cls.kind = rwlm_pkg::CMD_CLEAR;
			default:              cls.kind = rwlm_pkg::CMD_NOP;
		endcase
	end

	assign full      = cnt_q == 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = cmd_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	// Hold classified commands until the back end takes them
	always_ff @(posedge clk) begin
		if (do_push) begin
			cmd_q[wr_ptr_q] <= cls;
		end
	end

	// Advance queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// ===== rtl/rwlm_back.sv =====
// ----------------------------------------------------------------------------
// rwlm_back: lock table sequencer
// Carries out one command at a time against the per-resource lock and
// wait-queue state, and queues the results in a two-entry output queue.
// ----------------------------------------------------------------------------
module rwlm_back #(
	parameter int NUM_RESOURCES = 16,
	parameter int QUEUE_DEPTH   = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  rwlm_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           empty,
	input  logic           pop,
	output rwlm_pkg::rsp_t rsp
);

	localparam int RIW   = NUM_RESOURCES > 1 ? $clog2(NUM_RESOURCES) : 1;
	localparam int SW    = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int DEPTH = NUM_RESOURCES * QUEUE_DEPTH;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD_WAIT,
		ST_WR_WAIT
	} state_t;

	state_t            state_q;
	rwlm_pkg::cmd_t    cur_q;
	logic              lock_q  [NUM_RESOURCES];
	logic [SW-1:0]     rhead_q [NUM_RESOURCES];
	logic [CW-1:0]     rcnt_q  [NUM_RESOURCES];
	logic [SW-1:0]     whead_q [NUM_RESOURCES];
	logic [CW-1:0]     wcnt_q  [NUM_RESOURCES];

	logic [RIW-1:0]    ridx;
	logic              cur_lock;
	logic [SW-1:0]     cur_rhead;
	logic [CW-1:0]     cur_rcnt;
	logic [SW-1:0]     cur_whead;
	logic [CW-1:0]     cur_wcnt;
	logic              rfull;
	logic              wfull;
	logic [SW-1:0]     rtail;
	logic [SW-1:0]     wtail;
	logic [CW:0]       rsum;
	logic [CW:0]       wsum;
	logic [AW-1:0]     base;

	logic              rd_we;
	logic              wr_we;
	logic              rd_re;
	logic              wr_re;
	logic [AW-1:0]     rd_waddr;
	logic [AW-1:0]     wr_waddr;
	logic [AW-1:0]     rd_raddr;
	logic [AW-1:0]     wr_raddr;
	logic [7:0]        rd_rdata;
	logic [7:0]        wr_rdata;

	logic              res_push;
	logic              need_res;
	logic              step_ok;
	logic              drain_last;
	rwlm_pkg::rsp_t    res_data;
	rwlm_pkg::rsp_t    rq_q [2];
	logic              rq_wr_q;
	logic              rq_rd_q;
	logic [1:0]        rq_cnt_q;
	logic              space;

	// Look up the state of the current resource
	always_comb begin
		ridx      = RIW'(cur_q.resource);
		cur_lock  = lock_q[ridx];
		cur_rhead = rhead_q[ridx];
		cur_rcnt  = rcnt_q[ridx];
		cur_whead = whead_q[ridx];
		cur_wcnt  = wcnt_q[ridx];
		rfull     = cur_rcnt == CW'(QUEUE_DEPTH);
		wfull     = cur_wcnt == CW'(QUEUE_DEPTH);
		rsum      = (CW+1)'(cur_rhead) + (CW+1)'(cur_rcnt);
		wsum      = (CW+1)'(cur_whead) + (CW+1)'(cur_wcnt);
		rtail     = rsum >= (CW+1)'(QUEUE_DEPTH) ? SW'(rsum - (CW+1)'(QUEUE_DEPTH)) : SW'(rsum);
		wtail     = wsum >= (CW+1)'(QUEUE_DEPTH) ? SW'(wsum - (CW+1)'(QUEUE_DEPTH)) : SW'(wsum);
		base      = AW'(ridx) * AW'(QUEUE_DEPTH);
		drain_last = cur_rcnt == CW'(1) && cur_wcnt == '0;
	end

	assign space   = rq_cnt_q != 2'd2;
	assign cmd_pop = state_q == ST_IDLE && cmd_valid;

	// Decide the actions of the current step
	always_comb begin
		rd_we     = 1'b0;
		wr_we     = 1'b0;
		rd_re     = 1'b0;
		wr_re     = 1'b0;
		rd_waddr  = base + AW'(rtail);
		wr_waddr  = base + AW'(wtail);
		rd_raddr  = base + AW'(cur_rhead);
		wr_raddr  = base + AW'(cur_whead);
		need_res  = 1'b0;
		res_data.kind      = rwlm_pkg::KIND_DROP;
		res_data.grantee   = cur_q.requester;
		res_data.res_index = cur_q.resource;
		res_data.is_locked = 1'b1;
		res_data.last      = 1'b1;
		case (state_q)
			ST_EXEC: begin
				case (cur_q.kind)
					rwlm_pkg::CMD_READ: begin
						if (!cur_lock) begin
							need_res           = 1'b1;
							res_data.kind      = rwlm_pkg::KIND_READ;
							res_data.is_locked = 1'b0;
						end else if (rfull) begin
							need_res = 1'b1;
						end else begin
							rd_we = 1'b1;
						end
					end
					rwlm_pkg::CMD_WRITE: begin
						if (!cur_lock) begin
							need_res      = 1'b1;
							res_data.kind = rwlm_pkg::KIND_WRITE;
						end else if (wfull) begin
							need_res = 1'b1;
						end else begin
							wr_we = 1'b1;
						end
					end
					rwlm_pkg::CMD_RELEASE: begin
						rd_re = cur_rcnt != '0;
						wr_re = cur_rcnt == '0 && cur_wcnt != '0;
					end
					default: begin
					end
				endcase
			end
			ST_RD_WAIT: begin
				need_res           = 1'b1;
				res_data.kind      = rwlm_pkg::KIND_READ;
				res_data.grantee   = rd_rdata;
				res_data.is_locked = drain_last ? 1'b0 : cur_lock;
				res_data.last      = drain_last;
			end
			ST_WR_WAIT: begin
				need_res         = 1'b1;
				res_data.kind    = rwlm_pkg::KIND_WRITE;
				res_data.grantee = wr_rdata;
			end
			default: begin
			end
		endcase
		step_ok  = !need_res || space;
		res_push = need_res && space;
	end

	// Sequence commands and update the lock table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_q   <= '0;
			for (int i = 0; i < NUM_RESOURCES; i++) begin
				lock_q[i]  <= 1'b0;
				rhead_q[i] <= '0;
				rcnt_q[i]  <= '0;
				whead_q[i] <= '0;
				wcnt_q[i]  <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cur_q   <= cmd;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (step_ok) begin
						state_q <= ST_IDLE;
						case (cur_q.kind)
							rwlm_pkg::CMD_READ: begin
								if (rd_we) rcnt_q[ridx] <= cur_rcnt + CW'(1);
							end
							rwlm_pkg::CMD_WRITE: begin
								if (!cur_lock) lock_q[ridx] <= 1'b1;
								if (wr_we) wcnt_q[ridx] <= cur_wcnt + CW'(1);
							end
							rwlm_pkg::CMD_RELEASE: begin
								if (rd_re) begin
									state_q <= ST_RD_WAIT;
								end else if (wr_re) begin
									state_q <= ST_WR_WAIT;
								end else begin
									lock_q[ridx] <= 1'b0;
								end
							end
							rwlm_pkg::CMD_LOCK: begin
								lock_q[ridx] <= 1'b1;
							end
							rwlm_pkg::CMD_CLEAR: begin
								for (int i = 0; i < NUM_RESOURCES; i++) begin
									lock_q[i]  <= 1'b0;
									rhead_q[i] <= '0;
									rcnt_q[i]  <= '0;
									whead_q[i] <= '0;
									wcnt_q[i]  <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD_WAIT: begin
					if (space) begin
						rhead_q[ridx] <= 32'(cur_rhead) == QUEUE_DEPTH - 1 ? '0
							: cur_rhead + SW'(1);
						rcnt_q[ridx] <= cur_rcnt - CW'(1);
						if (drain_last) begin
							lock_q[ridx] <= 1'b0;
							state_q      <= ST_IDLE;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_WR_WAIT: begin
					if (space) begin
						whead_q[ridx] <= 32'(cur_whead) == QUEUE_DEPTH - 1 ? '0
							: cur_whead + SW'(1);
						wcnt_q[ridx] <= cur_wcnt - CW'(1);
						lock_q[ridx] <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Waiting reader and writer stores
	rwlm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_rd_ram (
		.clk   (clk),
		.we    (rd_we),
		.waddr (rd_waddr),
		.wdata (cur_q.requester),
		.re    (rd_re),
		.raddr (rd_raddr),
		.rdata (rd_rdata)
	);

	rwlm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_wr_ram (
		.clk   (clk),
		.we    (wr_we),
		.waddr (wr_waddr),
		.wdata (cur_q.requester),
		.re    (wr_re),
		.raddr (wr_raddr),
		.rdata (wr_rdata)
	);

	// Hold results until transfer
	always_ff @(posedge clk) begin
		if (res_push) begin
			rq_q[rq_wr_q] <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= 1'b0;
			rq_rd_q  <= 1'b0;
			rq_cnt_q <= 2'd0;
		end else begin
			if (res_push)       rq_wr_q <= !rq_wr_q;
			if (pop && !empty)  rq_rd_q <= !rq_rd_q;
			rq_cnt_q <= rq_cnt_q + 2'(res_push) - 2'(pop && !empty);
		end
	end

	assign empty = rq_cnt_q == 2'd0;
	assign rsp   = rq_q[rq_rd_q];

	// Checks
	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q != 2'd3) else $error("result queue overfilled");
	a_rd_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD_WAIT |-> cur_rcnt != '0) else $error("read drain on empty queue");
	a_wr_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR_WAIT |-> cur_wcnt != '0) else $error("write grant on empty queue");

endmodule

// ===== rtl/readers_writers_lock_manager.sv =====
// Path: a request passes the front-end queue, the back-end command register
// and the result queue; a full result queue stalls its grant or drop.
// Sequencing: one command at a time; a release grants waiting readers one by
// one and then a waiting writer, each from a registered wait-queue store read.
// Reset: arst_n clears all locks, queue heads and counts at once.
// ----------------------------------------------------------------------------
// readers_writers_lock_manager: readers-writers lock table
// Front end classifies requests into a short queue; back end grants,
// queues and drains waiting readers and writers per resource.
// ----------------------------------------------------------------------------
module readers_writers_lock_manager #(
	parameter int NUM_RESOURCES = 16,
	parameter int QUEUE_DEPTH   = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  rwlm_pkg::req_t req,
	output logic           empty,
	input  logic           pop,
	output rwlm_pkg::rsp_t rsp
);

	logic           cmd_valid;
	logic           cmd_pop;
	rwlm_pkg::cmd_t cmd;

	rwlm_front #(.NUM_RESOURCES(NUM_RESOURCES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	rwlm_back #(.NUM_RESOURCES(NUM_RESOURCES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

endmodule
